FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the monitor RTL.
// Depends on nothing; the using module provides clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASVM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASVM_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/asvm_pkg.sv
// Package of the averaged supply voltage monitor: sizes, constants, types.
// Depends on nothing.
package asvm_pkg;

   localparam int SAMPLE_COUNT = 16;
   localparam int SAMPLE_W     = 12;
   localparam int OUT_W        = 12;
   localparam int GAIN_W       = 15;
   localparam int SAMPLE_MAX   = 4095;
   localparam int OUT_MAX      = 4095;
   localparam int GAIN_RESET   = 10000;
   localparam int VOLT_MUL     = 77;
   localparam int VOLT_DIV     = 195;
   localparam int GAIN_SCALE   = 10000;

   localparam int SLOT_W  = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
   localparam int SUM_W   = $clog2(SAMPLE_COUNT * SAMPLE_MAX + 1);
   localparam int RND_W   = $clog2(SAMPLE_COUNT * SAMPLE_MAX + SAMPLE_COUNT / 2 + 1);
   localparam int PROD1_W = $clog2(OUT_MAX * VOLT_MUL + 1);
   localparam int Q1_MAX  = OUT_MAX * VOLT_MUL / VOLT_DIV;
   localparam int Q1_W    = $clog2(Q1_MAX + 1);
   localparam int GAIN_MAX = (1 << GAIN_W) - 1;
   localparam int PROD2_W = $clog2(Q1_MAX * GAIN_MAX + 1);

   // A quotient n / d with n below 2**k is (n * ceil(2**s / d)) >> s for
   // s = k + clog2(d).
   localparam int MEAN_SHIFT = RND_W + $clog2(SAMPLE_COUNT);
   localparam int Q1_SHIFT   = PROD1_W + $clog2(VOLT_DIV);
   localparam int VOLT_SHIFT = PROD2_W + $clog2(GAIN_SCALE);
   localparam longint MEAN_RECIP =
      ((longint'(1) << MEAN_SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
   localparam longint Q1_RECIP =
      ((longint'(1) << Q1_SHIFT) + VOLT_DIV - 1) / VOLT_DIV;
   localparam longint VOLT_RECIP =
      ((longint'(1) << VOLT_SHIFT) + GAIN_SCALE - 1) / GAIN_SCALE;
   localparam int MEAN_RECIP_W = $clog2(MEAN_RECIP + 1);
   localparam int Q1_RECIP_W   = $clog2(Q1_RECIP + 1);
   localparam int VOLT_RECIP_W = $clog2(VOLT_RECIP + 1);
   localparam int RECIP_W2 = (MEAN_RECIP_W > Q1_RECIP_W) ? MEAN_RECIP_W : Q1_RECIP_W;
   localparam int RECIP_W  = (RECIP_W2 > VOLT_RECIP_W) ? RECIP_W2 : VOLT_RECIP_W;

   localparam int MUL_A_W = (PROD2_W > RND_W) ? PROD2_W : RND_W;
   localparam int MUL_B_W = (RECIP_W > GAIN_W) ? RECIP_W : GAIN_W;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int VQ_W    = MUL_P_W - VOLT_SHIFT;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN    = 1'b1;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] operand_a;
      logic [MUL_B_W-1:0] operand_b;
   } div_ctl_type;

   typedef struct packed {
      logic [MUL_P_W-1:0] product;
   } div_sts_type;

endpackage

FILE: hw/rtl/asvm_if.sv
// Request and response channel interfaces of the voltage monitor.
// Depends on asvm_pkg.
interface asvm_req_if import asvm_pkg::*;;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink (input valid, input sample_value, output ready);
endinterface

interface asvm_rsp_if import asvm_pkg::*;;
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] voltage_centivolts;
   logic [OUT_W-1:0] mean_code;

   modport source (output valid, output voltage_centivolts, output mean_code, input ready);
   modport sink (input valid, input voltage_centivolts, input mean_code, output ready);
endinterface

FILE: hw/rtl/asvm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module asvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hw/rtl/asvm_div.sv
// Shared multiplier with a registered product; the constant divisions of the
// monitor run through it as reciprocal multiplications. Depends on asvm_pkg.
module asvm_div import asvm_pkg::*; (
   input  logic        clock,
   input  div_ctl_type ctl,
   output div_sts_type sts
);
   logic [MUL_P_W-1:0] product_ff, product_in;

   always_comb begin
      product_in = product_ff;
      if (ctl.start) begin
         product_in = ctl.operand_a * ctl.operand_b;
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign sts.product = product_ff;
endmodule

FILE: hw/rtl/averaged_supply_voltage_monitor_top.sv
// Top level of the averaged supply voltage monitor: sequencer, window and datapath.
// Depends on asvm_pkg, asvm_if, asvm_ram, asvm_div and assert_macros.svh.
//
// Each request on req_bus carries one 12-bit converter sample. While the enabled
// register is set, the sample replaces the oldest entry of a 16-entry window and
// the running sum is updated; while it is clear the sample is dropped. Either way
// one response follows on rsp_bus with the rounded window mean and the corrected
// voltage in hundredths of a volt.
// The csr port writes the enabled flag and the gain; write it only while idle.
// From acceptance, the UPD state updates the window (skipped when disabled), the
// states MEAN, MUL1, Q1, MUL2 and VOLT run the shared multiplier for the mean,
// the 77 scaling, the division by 195, the gain and the division by 10000, and
// the DONE state loads the response register; the divisions are reciprocal
// multiplications. A new request is taken only once the sequencer is back in idle.
// The response waits in an output register; the next request is accepted while
// it waits, and its result is held back until the receiver takes the first one.
// Reset is synchronous; it empties the window, clears the sum and the write slot,
// disables sampling and loads the gain with 10000.
`include "assert_macros.svh"

module averaged_supply_voltage_monitor_top import asvm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   asvm_req_if.sink             req_bus,
   asvm_rsp_if.source           rsp_bus,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_data
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_UPD  = 8'b00000010,
      S_MEAN = 8'b00000100,
      S_MUL1 = 8'b00001000,
      S_Q1   = 8'b00010000,
      S_MUL2 = 8'b00100000,
      S_VOLT = 8'b01000000,
      S_DONE = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   logic                    enabled_ff, enabled_in;
   logic [GAIN_W-1:0]       gain_ff, gain_in;
   logic [SAMPLE_W-1:0]     sample_ff, sample_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [SAMPLE_COUNT-1:0] valid_ff, valid_in;
   logic [OUT_W-1:0]        mean_ff, mean_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]        rsp_volt_ff, rsp_volt_in;
   logic [OUT_W-1:0]        rsp_mean_ff, rsp_mean_in;

   logic                    req_take;
   logic                    rsp_free;
   logic [SAMPLE_W-1:0]     ram_rdata;
   logic [SAMPLE_W-1:0]     old_sample;
   logic                    ram_we;
   logic [RND_W-1:0]        rounded_sum;
   logic [OUT_W-1:0]        mean_quot;
   logic [VQ_W-1:0]         volt_quot;
   div_ctl_type             div_ctl;
   div_sts_type             div_sts;

   asvm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (SAMPLE_COUNT)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_addr (slot_ff),
      .rd_data (ram_rdata)
   );

   asvm_div u_div (
      .clock (clock),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   assign req_bus.ready = state_ff == S_IDLE;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign old_sample    = valid_ff[slot_ff] ? ram_rdata : '0;
   assign ram_we        = state_ff == S_UPD;
   assign rounded_sum   = RND_W'(sum_ff) + RND_W'(SAMPLE_COUNT / 2);
   assign mean_quot     = div_sts.product[MEAN_SHIFT +: OUT_W];
   assign volt_quot     = div_sts.product[MUL_P_W-1:VOLT_SHIFT];

   always_comb begin
      enabled_in = enabled_ff;
      gain_in    = gain_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ENABLED: enabled_in = csr_data[0];
            CSR_GAIN:    gain_in    = csr_data;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      slot_in      = slot_ff;
      sum_in       = sum_ff;
      valid_in     = valid_ff;
      mean_in      = mean_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_volt_in  = rsp_volt_ff;
      rsp_mean_in  = rsp_mean_ff;
      div_ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               sample_in = req_bus.sample_value;
               state_in  = enabled_ff ? S_UPD : S_MEAN;
            end
         end
         S_UPD: begin
            sum_in            = sum_ff - SUM_W'(old_sample) + SUM_W'(sample_ff);
            valid_in[slot_ff] = 1'b1;
            slot_in = (slot_ff == SLOT_W'(SAMPLE_COUNT - 1)) ? '0 : slot_ff + 1'b1;
            state_in = S_MEAN;
         end
         S_MEAN: begin
            div_ctl.start     = 1'b1;
            div_ctl.operand_a = MUL_A_W'(rounded_sum);
            div_ctl.operand_b = MUL_B_W'(MEAN_RECIP);
            state_in          = S_MUL1;
         end
         S_MUL1: begin
            mean_in           = mean_quot;
            div_ctl.start     = 1'b1;
            div_ctl.operand_a = MUL_A_W'(mean_quot);
            div_ctl.operand_b = MUL_B_W'(VOLT_MUL);
            state_in          = S_Q1;
         end
         S_Q1: begin
            div_ctl.start     = 1'b1;
            div_ctl.operand_a = MUL_A_W'(div_sts.product[PROD1_W-1:0]);
            div_ctl.operand_b = MUL_B_W'(Q1_RECIP);
            state_in          = S_MUL2;
         end
         S_MUL2: begin
            div_ctl.start     = 1'b1;
            div_ctl.operand_a = MUL_A_W'(div_sts.product[Q1_SHIFT +: Q1_W]);
            div_ctl.operand_b = MUL_B_W'(gain_ff);
            state_in          = S_VOLT;
         end
         S_VOLT: begin
            div_ctl.start     = 1'b1;
            div_ctl.operand_a = MUL_A_W'(div_sts.product[PROD2_W-1:0]);
            div_ctl.operand_b = MUL_B_W'(VOLT_RECIP);
            state_in          = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               rsp_volt_in  = (volt_quot > VQ_W'(OUT_MAX)) ?
                              OUT_W'(OUT_MAX) : volt_quot[OUT_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enabled_ff   <= 1'b0;
         gain_ff      <= GAIN_W'(GAIN_RESET);
         slot_ff      <= '0;
         sum_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enabled_ff   <= enabled_in;
         gain_ff      <= gain_in;
         slot_ff      <= slot_in;
         sum_ff       <= sum_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      mean_ff     <= mean_in;
      rsp_volt_ff <= rsp_volt_in;
      rsp_mean_ff <= rsp_mean_in;
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.voltage_centivolts = rsp_volt_ff;
   assign rsp_bus.mean_code          = rsp_mean_ff;

   `ASVM_ASSERT(a_rsp_hold, rsp_valid_ff && !rsp_bus.ready |=> rsp_valid_ff && $stable(rsp_volt_ff), "stalled response changed")
   `ASVM_ASSERT(a_slot_range, slot_ff <= SLOT_W'(SAMPLE_COUNT - 1), "write slot out of range")
   `ASVM_ASSERT(a_sum_bound, sum_ff <= SUM_W'(SAMPLE_COUNT * SAMPLE_MAX), "running sum overflow")
   `ASVM_ASSERT_RST(a_reset_rsp, reset |=> !rsp_valid_ff, "response valid after reset")
endmodule
